// ----- design/relocating_object_loader_top_defines.svh -----
// Assertion macros for the relocating object loader.
`ifndef RELOCATING_OBJECT_LOADER_TOP_DEFINES_SVH
`define RELOCATING_OBJECT_LOADER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ROL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ROL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rol_pkg.sv -----
package rol_pkg;

    localparam int HW_W   = 16;
    localparam int ADDR_W = 16;
    localparam int CNT_W  = 8;

    localparam logic [HW_W-1:0] MARKER_WORD = 16'hFFFC;

    // Header class codes in the top two bits.
    localparam logic [1:0] HDR_ORG  = 2'b11;
    localparam logic [1:0] HDR_DATA = 2'b10;

    // Relocation multiplier for one instruction word.
    typedef enum logic [1:0] {
        RELOC_NONE   = 2'd0,
        RELOC_ONCE   = 2'd1,
        RELOC_TWICE  = 2'd2
    } reloc_t;

endpackage

// ----- design/rol_if.sv -----
interface rol_obj_if;
    logic                      valid;
    logic                      ready;
    logic [rol_pkg::HW_W-1:0]  halfword;

    modport source (output valid, output halfword, input ready);
    modport sink   (input valid, input halfword, output ready);
endinterface

interface rol_wr_if;
    logic                        valid;
    logic                        ready;
    logic [rol_pkg::ADDR_W-1:0]  write_address;
    logic [rol_pkg::HW_W-1:0]    write_data;
    logic                        last_of_run;

    modport source (output valid, output write_address, output write_data,
                    output last_of_run, input ready);
    modport sink   (input valid, input write_address, input write_data,
                    input last_of_run, output ready);
endinterface

interface rol_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rol_pkg::ADDR_W-1:0]  relocation_offset;

    modport source (output valid, output relocation_offset, input ready);
    modport sink   (input valid, input relocation_offset, output ready);
endinterface

// ----- design/relocating_object_loader_top.sv -----
// Relocating object loader.
// obj: one object halfword per request. wr: memory write requests (address,
// data, last_of_run flag on the final write caused by one halfword).
// cfg: writes the relocation offset and reloads the write address with it;
// issue it only while the loader is idle. It is always ready.
// Path: a halfword is held in the input register and decoded, and its
// first write is loaded into the output register, which offers it on wr;
// a stall on wr can hold the halfword in the input register first.
// Throughput: one halfword per cycle while wr does not stall. The single
// exception is the data record that places the end marker: its last halfword
// gives two writes, and the input register holds while the second drains.
// The 16-bit adds in the decode path stand side by side; none feeds another.
// Reset: offset and address go to zero, the decoder waits for a header and
// no request is offered. When wr stalls, the output register holds its
// request, the input register fills and then obj ready drops.
`include "relocating_object_loader_top_defines.svh"

module relocating_object_loader_top (
    input  logic      clk,
    input  logic      rst_n,
    rol_obj_if.sink   obj,
    rol_wr_if.source  wr,
    rol_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_INSTR  = 2'd2
    } phase_t;

    // Input register
    logic                         in_valid_reg;
    logic [rol_pkg::HW_W-1:0]     hw_reg;

    // Decoder state
    phase_t                       phase_reg, phase_next;
    logic [rol_pkg::ADDR_W-1:0]   offset_reg;
    logic [rol_pkg::ADDR_W-1:0]   cur_addr_reg, cur_addr_next;
    logic                         marker_written_reg, marker_written_next;
    logic [rol_pkg::CNT_W-1:0]    data_left_reg, data_left_next;
    logic [1:0]                   instr_len_reg, instr_len_next;
    logic [1:0]                   instr_pos_reg, instr_pos_next;
    logic [1:0]                   first_code_reg, first_code_next;
    logic [1:0]                   second_code_reg, second_code_next;

    // Output register
    logic                         out_valid_reg;
    logic [rol_pkg::ADDR_W-1:0]   out_addr_reg;
    logic [rol_pkg::HW_W-1:0]     out_data_reg;
    logic                         out_last_reg;
    logic                         marker_pend_reg;

    // Result of the current item
    logic                         res_valid;
    logic                         res_two;
    logic [rol_pkg::ADDR_W-1:0]   res_addr;
    logic [rol_pkg::HW_W-1:0]     res_data;
    logic                         res_last;

    logic                         out_free;
    logic                         adv;
    logic                         fire;
    logic [1:0]                   pos_inc;
    rol_pkg::reloc_t              times;
    logic [rol_pkg::HW_W-1:0]     reloc_add;
    logic [7:0]                   lo_byte;

    assign out_free  = !out_valid_reg || wr.ready;
    assign adv       = out_free && !marker_pend_reg;
    assign fire      = in_valid_reg && adv;
    assign obj.ready = !in_valid_reg || adv;
    assign cfg.ready = 1'b1;

    assign wr.valid         = out_valid_reg;
    assign wr.write_address = out_addr_reg;
    assign wr.write_data    = out_data_reg;
    assign wr.last_of_run   = out_last_reg;

    assign lo_byte = hw_reg[7:0];
    assign pos_inc = instr_pos_reg + 2'd1;

    // Pick how many times the offset is added to this instruction word
    always_comb
    begin
        times = rol_pkg::RELOC_NONE;
        if (instr_len_reg == 2'd1)
        begin
            if (first_code_reg != 2'd0)
                times = rol_pkg::RELOC_ONCE;
        end
        else if (instr_len_reg == 2'd2)
        begin
            if (instr_pos_reg == 2'd1)
            begin
                if ((first_code_reg != 2'd0) && (second_code_reg != 2'd0))
                    times = rol_pkg::RELOC_TWICE;
                else if ((first_code_reg != 2'd0) || (second_code_reg != 2'd0))
                    times = rol_pkg::RELOC_ONCE;
            end
        end
        else
        begin
            if ((instr_pos_reg == 2'd1) && (first_code_reg != 2'd0))
                times = rol_pkg::RELOC_ONCE;
            else if ((instr_pos_reg == 2'd2) && (second_code_reg != 2'd0))
                times = rol_pkg::RELOC_ONCE;
        end
    end

    always_comb
    begin
        case (times)
            rol_pkg::RELOC_ONCE:  reloc_add = offset_reg;
            rol_pkg::RELOC_TWICE: reloc_add = {offset_reg[rol_pkg::HW_W-2:0], 1'b0};
            default:              reloc_add = '0;
        endcase
    end

    // Decode the held halfword against the decoder state
    always_comb
    begin
        phase_next          = phase_reg;
        cur_addr_next       = cur_addr_reg;
        marker_written_next = marker_written_reg;
        data_left_next      = data_left_reg;
        instr_len_next      = instr_len_reg;
        instr_pos_next      = instr_pos_reg;
        first_code_next     = first_code_reg;
        second_code_next    = second_code_reg;
        res_valid           = 1'b0;
        res_two             = 1'b0;
        res_addr            = cur_addr_reg;
        res_data            = hw_reg;
        res_last            = 1'b1;

        unique case (phase_reg)
            PH_DATA:
            begin
                res_valid      = 1'b1;
                cur_addr_next  = cur_addr_reg + 16'd2;
                data_left_next = data_left_reg - 8'd1;
                if (data_left_reg == 8'd1)
                begin
                    phase_next = PH_HEADER;
                    if (!marker_written_reg)
                    begin
                        res_two             = 1'b1;
                        res_last            = 1'b0;
                        marker_written_next = 1'b1;
                    end
                end
            end
            PH_INSTR:
            begin
                res_valid      = 1'b1;
                res_data       = hw_reg + reloc_add;
                cur_addr_next  = cur_addr_reg + 16'd2;
                instr_pos_next = pos_inc;
                if (pos_inc >= instr_len_reg)
                begin
                    phase_next     = PH_HEADER;
                    instr_pos_next = 2'd0;
                end
            end
            default:
            begin
                if (hw_reg[15:14] == rol_pkg::HDR_ORG)
                begin
                    cur_addr_next = offset_reg + {7'd0, lo_byte, 1'b0};
                end
                else if (hw_reg[15:14] == rol_pkg::HDR_DATA)
                begin
                    data_left_next = lo_byte;
                    if (lo_byte == 8'd0)
                    begin
                        // Empty record: place the marker over the last slot
                        if (!marker_written_reg)
                        begin
                            res_valid           = 1'b1;
                            res_addr            = cur_addr_reg - 16'd2;
                            res_data            = rol_pkg::MARKER_WORD;
                            marker_written_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    instr_len_next   = hw_reg[10:9];
                    second_code_next = hw_reg[12:11];
                    first_code_next  = hw_reg[14:13];
                    instr_pos_next   = 2'd0;
                    if (hw_reg[10:9] != 2'd0)
                        phase_next = PH_INSTR;
                end
            end
        endcase
    end

    // Hold state, input register and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            hw_reg             <= '0;
            phase_reg          <= PH_HEADER;
            offset_reg         <= '0;
            cur_addr_reg       <= '0;
            marker_written_reg <= 1'b0;
            data_left_reg      <= '0;
            instr_len_reg      <= '0;
            instr_pos_reg      <= '0;
            first_code_reg     <= '0;
            second_code_reg    <= '0;
            out_valid_reg      <= 1'b0;
            out_addr_reg       <= '0;
            out_data_reg       <= '0;
            out_last_reg       <= 1'b0;
            marker_pend_reg    <= 1'b0;
        end
        else
        begin
            // Take a new request into the input register
            if (obj.ready)
            begin
                in_valid_reg <= obj.valid;
                if (obj.valid)
                    hw_reg <= obj.halfword;
            end

            // Write the offset and reload the address, or advance the decoder
            if (cfg.valid)
            begin
                offset_reg   <= cfg.relocation_offset;
                cur_addr_reg <= cfg.relocation_offset;
            end
            else if (fire)
            begin
                phase_reg          <= phase_next;
                cur_addr_reg       <= cur_addr_next;
                marker_written_reg <= marker_written_next;
                data_left_reg      <= data_left_next;
                instr_len_reg      <= instr_len_next;
                instr_pos_reg      <= instr_pos_next;
                first_code_reg     <= first_code_next;
                second_code_reg    <= second_code_next;
            end

            // Load the output register: pending marker first, then new result
            if (out_free)
            begin
                if (marker_pend_reg)
                begin
                    out_valid_reg   <= 1'b1;
                    out_data_reg    <= rol_pkg::MARKER_WORD;
                    out_last_reg    <= 1'b1;
                    marker_pend_reg <= 1'b0;
                end
                else if (fire && res_valid)
                begin
                    out_valid_reg   <= 1'b1;
                    out_addr_reg    <= res_addr;
                    out_data_reg    <= res_data;
                    out_last_reg    <= res_last;
                    marker_pend_reg <= res_two;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    `ROL_ASSERT_NOW(a_pend_has_out, marker_pend_reg, out_valid_reg && !out_last_reg,
        "marker pending without the data write in the output register")
    `ROL_ASSERT_NOW(a_pend_marks, marker_pend_reg, marker_written_reg,
        "marker pending but not recorded as written")
    `ROL_ASSERT_NOW(a_data_count, phase_reg == PH_DATA, data_left_reg != 8'd0,
        "data record open with zero halfwords left")
    `ROL_ASSERT_NEXT(a_marker_out, !marker_written_reg && !cfg.valid && fire
        && res_valid && marker_written_next,
        marker_pend_reg || (out_valid_reg && out_data_reg == rol_pkg::MARKER_WORD),
        "marker recorded but no marker write issued")

endmodule
